>>> sv/nmea_rmc_speed_parser_core_macros.svh
// Assertion helpers shared by the parser modules.
`ifndef NMEA_RMC_SPEED_PARSER_CORE_MACROS_SVH
`define NMEA_RMC_SPEED_PARSER_CORE_MACROS_SVH

// Check a property on the rising edge, ignored while reset is asserted.
`define NRSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property on the rising edge at all times, reset included.
`define NRSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> sv/nrsp_pkg.sv
package nrsp_pkg;

  // Characters of interest in the sentence stream
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  // Field index of speed over ground, header length
  localparam logic [2:0] SpeedField = 3'd7;
  localparam int unsigned HdrLen    = 6;

  // Knots to km/h: (tenths * 1852) / 10000, divide done by reciprocal
  localparam logic [31:0] KnotMul   = 32'd1852;
  localparam logic [31:0] DivRecip  = 32'd3518437209;
  localparam int unsigned DivShift  = 45;

  // Line-end queue depth
  localparam int unsigned FifoDepth = 4;

  // One finished line handed from the front to the back
  typedef struct packed {
    logic        ok;
    logic [23:0] knots;
  } evt_t;

  // Expected header text, one character per position
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> sv/nrsp_front.sv
`include "nmea_rmc_speed_parser_core_macros.svh"

module nrsp_front #(
  parameter int unsigned LINE_MAX = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    rx_byte_i,
  output logic          evt_valid_o,
  output nrsp_pkg::evt_t evt_o,
  input  logic          evt_ready_i
);
  import nrsp_pkg::*;

  localparam int unsigned PosW = $clog2(LINE_MAX);
  localparam logic [PosW-1:0] PosMax = PosW'(LINE_MAX - 1);
  localparam logic [PosW-1:0] PosHdr = PosW'(HdrLen);

  typedef struct packed {
    logic        hdr;
    logic [2:0]  fnum;
    logic [3:0]  flen;
    logic [1:0]  dots;
    logic        bad;
    logic [23:0] knots;
    logic        dot_seen;
    logic        frac;
    logic        stopped;
    logic [23:0] cand_k;
    logic        cand_v;
  } scan_t;

  localparam scan_t ScanClr = '{hdr: 1'b1, default: '0};

  scan_t           scan_q, scan_d, base, nxt;
  logic [PosW-1:0] pos_q, pos_d, base_pos, nxt_pos;
  logic            accept, is_dollar, is_lf, is_digit;

  assign in_ready_o = evt_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_dollar  = (rx_byte_i == CharDollar);
  assign is_lf      = (rx_byte_i == CharLf);
  assign is_digit   = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);

  // Classify the byte against the line state
  always_comb begin
    base     = is_dollar ? ScanClr : scan_q;
    base_pos = is_dollar ? '0 : pos_q;
    nxt      = base;
    nxt_pos  = base_pos;
    if (base_pos < PosMax) begin
      if (base_pos < PosHdr && rx_byte_i != hdr_char(base_pos[2:0])) begin
        nxt.hdr = 1'b0;
      end
      if (!base.stopped) begin
        priority if (rx_byte_i == CharNul) begin
          nxt.stopped = 1'b1;
        end else if (rx_byte_i == CharComma || rx_byte_i == CharStar) begin
          if (base.fnum == SpeedField) begin
            nxt.cand_v  = (base.flen >= 4'd3) && (base.flen <= 4'd7) &&
                          !base.bad && (base.dots == 2'd1);
            if (nxt.cand_v) begin
              nxt.cand_k = base.knots;
            end
            nxt.stopped = 1'b1;
          end else begin
            nxt.fnum = base.fnum + 3'd1;
          end
        end else if (base.fnum == SpeedField) begin
          if (base.flen < 4'd8) begin
            nxt.flen = base.flen + 4'd1;
          end
          priority if (rx_byte_i == CharDot) begin
            if (base.dots < 2'd2) begin
              nxt.dots = base.dots + 2'd1;
            end
            nxt.dot_seen = 1'b1;
          end else if (is_digit) begin
            if (!base.frac) begin
              nxt.knots = (base.knots << 3) + (base.knots << 1) +
                          {20'd0, rx_byte_i[3:0]};
              if (base.dot_seen) begin
                nxt.frac = 1'b1;
              end
            end
          end else begin
            nxt.bad = 1'b1;
          end
        end
      end
      nxt_pos = base_pos + PosW'(1);
    end
  end

  // Hand a finished line to the queue
  assign evt_valid_o = accept && is_lf;
  assign evt_o.ok    = nxt.hdr && (nxt_pos >= PosHdr) && nxt.cand_v;
  assign evt_o.knots = nxt.cand_k;

  // Advance the line state, restart at a dollar or after a line feed
  always_comb begin
    scan_d = scan_q;
    pos_d  = pos_q;
    if (accept) begin
      if (is_lf) begin
        scan_d = ScanClr;
        pos_d  = '0;
      end else begin
        scan_d = nxt;
        pos_d  = nxt_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= ScanClr;
      pos_q  <= '0;
    end else begin
      scan_q <= scan_d;
      pos_q  <= pos_d;
    end
  end

  `NRSP_ASSERT(a_dollar_restart, clk_i, rst_ni,
    (accept && is_dollar) |=> (pos_q == PosW'(1)), "dollar did not restart line")
  `NRSP_ASSERT_ALWAYS(a_pos_bound, clk_i, (!rst_ni || (pos_q <= PosMax)),
    "line position overrun")

endmodule

>>> sv/nrsp_fifo.sv
`include "nmea_rmc_speed_parser_core_macros.svh"

module nrsp_fifo #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `NRSP_ASSERT_ALWAYS(a_cnt_bound, clk_i, (!rst_ni || (cnt_q <= CntFull)),
    "queue count overrun")
  `NRSP_ASSERT(a_ptr_gap, clk_i, rst_ni,
    (cnt_q == '0 || cnt_q == CntFull) |-> (wr_q == rd_q), "queue pointers out of step")

endmodule

>>> sv/nrsp_back.sv
`include "nmea_rmc_speed_parser_core_macros.svh"

module nrsp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           evt_valid_i,
  input  nrsp_pkg::evt_t evt_i,
  output logic           evt_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [15:0]    speed_kmph_o,
  output logic           speed_updated_o
);
  import nrsp_pkg::*;

  logic        en;
  logic        v1_q, v2_q, out_valid_q;
  logic        ok1_q, ok2_q, upd_q;
  logic [31:0] prod1_d, prod1_q;
  logic [63:0] prod2_d, prod2_q;
  logic [15:0] quot, speed_d, speed_q, held_q;

  // Move the whole pipeline unless the result register is stalled
  assign en          = !out_valid_q || out_ready_i;
  assign evt_ready_o = en;

  // Scale tenths of a knot, then divide by reciprocal multiply
  assign prod1_d = 32'(evt_i.knots) * KnotMul;
  assign prod2_d = {32'd0, prod1_q} * {32'd0, DivRecip};
  assign quot    = prod2_q[DivShift+15:DivShift];
  assign speed_d = ok2_q ? quot : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= 16'd1;
    end else if (en) begin
      v1_q        <= evt_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
      if (v2_q) begin
        held_q <= speed_d;
      end
    end
  end

  // Hold payload stages along with the valid bits
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok1_q   <= evt_i.ok;
      prod1_q <= prod1_d;
      ok2_q   <= ok1_q;
      prod2_q <= prod2_d;
      if (v2_q) begin
        speed_q <= speed_d;
        upd_q   <= ok2_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speed_kmph_o    = speed_q;
  assign speed_updated_o = upd_q;

  `NRSP_ASSERT(a_out_is_held, clk_i, rst_ni,
    out_valid_q |-> (speed_q == held_q), "shown speed differs from held speed")
  `NRSP_ASSERT(a_stall_freeze, clk_i, rst_ni,
    !en |=> ($stable(v1_q) && $stable(v2_q)), "pipeline moved during stall")

endmodule

>>> sv/nmea_rmc_speed_parser_core.sv
// NMEA RMC speed-over-ground parser.
// Input channel: one received byte per item (in_valid_i / in_ready_o,
// rx_byte_i). Output channel: one item per line feed (out_valid_o /
// out_ready_i) with speed_kmph_o, the held speed in km/h after that line,
// and speed_updated_o, set when the line was a $GNRMC sentence with a valid
// speed field. Other bytes produce no output item.
// Throughput: one byte per cycle while the queue has room. The front updates
// the line state in the cycle a byte is taken; a line feed enters a 4-entry
// queue, and the back runs a two-multiplier pipeline (scale by 1852,
// reciprocal divide by 10000) plus a result register.
// When the receiver stalls, the result register and pipeline hold; the
// front keeps taking bytes until the queue fills, then drops in_ready_o.
// Reset clears the line state, empties the queue and sets the held speed
// to 1; no clearing pass is needed.
module nmea_rmc_speed_parser_core #(
  parameter int unsigned LINE_MAX = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] speed_kmph_o,
  output logic        speed_updated_o
);
  import nrsp_pkg::*;

  localparam int unsigned EvtW = $bits(evt_t);

  evt_t front_evt, back_evt;
  logic front_valid, front_ready, back_valid, back_ready;

  nrsp_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .evt_valid_o (front_valid),
    .evt_o       (front_evt),
    .evt_ready_i (front_ready)
  );

  nrsp_fifo #(
    .WIDTH (EvtW),
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_evt),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_evt)
  );

  nrsp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .evt_valid_i     (back_valid),
    .evt_i           (back_evt),
    .evt_ready_o     (back_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .speed_kmph_o    (speed_kmph_o),
    .speed_updated_o (speed_updated_o)
  );

endmodule
